// File: rtl/ata_taskfile_command_issue_defines.svh
// ----------------------------------------------------------------------------
// ATA task-file command issue: assertion macros
// Shared property wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ATA_TASKFILE_COMMAND_ISSUE_DEFINES_SVH
`define ATA_TASKFILE_COMMAND_ISSUE_DEFINES_SVH

// same-cycle implication
`define ATF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ATF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ata_tf_pkg.sv
// ----------------------------------------------------------------------------
// ata_tf_pkg
// Types and constants of the ATA task-file command issue block.
// ----------------------------------------------------------------------------
package ata_tf_pkg;

	// geometry defaults
	localparam int SPT_DEFAULT   = 63;
	localparam int HEADS_DEFAULT = 16;

	// CHS math only ever sees addresses below the 48-bit threshold
	localparam int LBA_CHS_W = 28;
	localparam logic [31:0] LBA48_MIN = 32'h1000_0000;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_LBA_SUPPORTED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_BASE  = 2'd2;

	localparam logic [15:0] COMMAND_BASE_RST = 16'h01F0;
	localparam logic [15:0] CONTROL_BASE_RST = 16'h03F6;

	// register offsets
	localparam logic [2:0] REG_DEVCTL  = 3'd2;  // control block
	localparam logic [2:0] REG_SECCNT  = 3'd2;
	localparam logic [2:0] REG_LBA_LO  = 3'd3;
	localparam logic [2:0] REG_LBA_MID = 3'd4;
	localparam logic [2:0] REG_LBA_HI  = 3'd5;
	localparam logic [2:0] REG_DEVSEL  = 3'd6;
	localparam logic [2:0] REG_COMMAND = 3'd7;

	// data codes
	localparam logic [7:0] CTL_NIEN    = 8'h02;
	localparam logic [7:0] CTL_HOB_ON  = 8'h81;
	localparam logic [7:0] CTL_HOB_OFF = 8'h01;
	localparam logic [7:0] DEV_CHS     = 8'hA0;
	localparam logic [7:0] DEV_LBA     = 8'hE0;
	localparam logic [7:0] CMD_READ      = 8'h20;
	localparam logic [7:0] CMD_WRITE     = 8'h30;
	localparam logic [7:0] CMD_READ_EXT  = 8'h24;
	localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
	localparam logic       REQ_WRITE     = 1'b1;

	// decoded request handed to the write sequencer
	typedef struct packed {
		logic       ext;
		logic [7:0] devsel;
		logic [7:0] hob_lba;
		logic [7:0] count;
		logic [7:0] b2;
		logic [7:0] b1;
		logic [7:0] b0;
		logic [7:0] cmd;
	} item_t;

	// one step per port write, in bus order
	typedef enum logic [4:0] {
		ST_NIEN,
		ST_DEV,
		ST_H_CNT_ON,
		ST_H_CNT,
		ST_H_CNT_OFF,
		ST_H_LO_ON,
		ST_H_LO,
		ST_H_LO_OFF,
		ST_H_MID_ON,
		ST_H_MID,
		ST_H_MID_OFF,
		ST_H_HI_ON,
		ST_H_HI,
		ST_H_HI_OFF,
		ST_CNT,
		ST_HI,
		ST_MID,
		ST_LO,
		ST_CMD
	} step_t;

endpackage

// File: rtl/ata_tf_addr.sv
// ----------------------------------------------------------------------------
// ata_tf_addr
// Request pipeline: input register, reciprocal multiplies, quotient
// correction, and decode into the address, device and command bytes of the task file.
// ----------------------------------------------------------------------------
`include "ata_taskfile_command_issue_defines.svh"

module ata_tf_addr import ata_tf_pkg::*; #(
	parameter int SECTORS_PER_TRACK = SPT_DEFAULT,
	parameter int HEADS = HEADS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [31:0] block_address,
	input  logic [7:0]  sector_count,
	input  logic        lba_supported,
	output item_t       item,
	output logic        item_valid,
	input  logic        pop
);

	localparam int RecipW = LBA_CHS_W + 1;
	localparam int ProdW  = LBA_CHS_W + RecipW;
	localparam int CylDiv = SECTORS_PER_TRACK * HEADS;
	localparam int RemW   = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;
	// floor(2^28 / d): estimate is low by at most one
	localparam logic [RecipW-1:0] RecipSpt =
		RecipW'((64'd1 << LBA_CHS_W) / SECTORS_PER_TRACK);
	localparam logic [RecipW-1:0] RecipCyl =
		RecipW'((64'd1 << LBA_CHS_W) / CylDiv);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic        write_s1, write_s2, write_s3;
	logic [31:0] lba_s1, lba_s2, lba_s3;
	logic [7:0]  count_s1, count_s2, count_s3;
	logic [ProdW-1:0] prod_spt_s2, prod_cyl_s2;
	logic [LBA_CHS_W-1:0] q_s3, cyl_s3;
	logic [RemW-1:0] r_s3;
	item_t item_s4;

	// stage 2 products
	logic [ProdW-1:0] prod_spt, prod_cyl;
	// stage 3 correction
	logic [LBA_CHS_W-1:0] q_est, r_est, q_fix, r_fix;
	logic [LBA_CHS_W-1:0] c_est, rc_est, c_fix;
	logic fix_q, fix_c;
	// stage 4 decode
	logic [LBA_CHS_W-1:0] head_full;
	logic ext_s3;
	item_t item_d;

	assign rdy4 = !v_s4 || pop;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req_stall = !rdy1;

	assign prod_spt = ProdW'(lba_s1[LBA_CHS_W-1:0]) * ProdW'(RecipSpt);
	assign prod_cyl = ProdW'(lba_s1[LBA_CHS_W-1:0]) * ProdW'(RecipCyl);

	always_comb begin
		q_est  = prod_spt_s2[LBA_CHS_W +: LBA_CHS_W];
		r_est  = lba_s2[LBA_CHS_W-1:0] - LBA_CHS_W'(q_est * SECTORS_PER_TRACK);
		fix_q  = r_est >= LBA_CHS_W'(SECTORS_PER_TRACK);
		q_fix  = q_est + LBA_CHS_W'(fix_q);
		r_fix  = fix_q ? r_est - LBA_CHS_W'(SECTORS_PER_TRACK) : r_est;
		c_est  = prod_cyl_s2[LBA_CHS_W +: LBA_CHS_W];
		rc_est = lba_s2[LBA_CHS_W-1:0] - LBA_CHS_W'(c_est * CylDiv);
		fix_c  = rc_est >= LBA_CHS_W'(CylDiv);
		c_fix  = c_est + LBA_CHS_W'(fix_c);
	end

	always_comb begin
		ext_s3    = lba_s3 >= LBA48_MIN;
		head_full = q_s3 - LBA_CHS_W'(cyl_s3 * HEADS);
		item_d.ext     = ext_s3;
		item_d.hob_lba = lba_s3[31:24];
		item_d.count   = count_s3;
		if (ext_s3 || lba_supported) begin
			item_d.b0     = lba_s3[7:0];
			item_d.b1     = lba_s3[15:8];
			item_d.b2     = lba_s3[23:16];
			item_d.devsel = ext_s3 ? DEV_LBA : (DEV_LBA | {4'h0, lba_s3[27:24]});
		end else begin
			item_d.b0     = 8'(r_s3) + 8'd1;
			item_d.b1     = cyl_s3[7:0];
			item_d.b2     = cyl_s3[15:8];
			item_d.devsel = DEV_CHS | {4'h0, head_full[3:0]};
		end
		if (write_s3 == REQ_WRITE)
			item_d.cmd = ext_s3 ? CMD_WRITE_EXT : CMD_WRITE;
		else
			item_d.cmd = ext_s3 ? CMD_READ_EXT : CMD_READ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && rdy1) begin
			write_s1 <= req_type;
			lba_s1   <= block_address;
			count_s1 <= sector_count;
		end
		if (v_s1 && rdy2) begin
			write_s2    <= write_s1;
			lba_s2      <= lba_s1;
			count_s2    <= count_s1;
			prod_spt_s2 <= prod_spt;
			prod_cyl_s2 <= prod_cyl;
		end
		if (v_s2 && rdy3) begin
			write_s3 <= write_s2;
			lba_s3   <= lba_s2;
			count_s3 <= count_s2;
			q_s3     <= q_fix;
			r_s3     <= r_fix[RemW-1:0];
			cyl_s3   <= c_fix;
		end
		if (v_s3 && rdy4)
			item_s4 <= item_d;
	end

	assign item       = item_s4;
	assign item_valid = v_s4;

	`ATF_ASSERT_NOW(a_rem_range, clk, arst_n, v_s3, 32'(r_s3) < SECTORS_PER_TRACK, "sector remainder not reduced")
	`ATF_ASSERT_NOW(a_chs_fields, clk, arst_n, v_s4 && !item_s4.devsel[6], (item_s4.b0 != 8'd0) && (32'(item_s4.devsel[3:0]) < HEADS), "CHS sector or head out of range")
	`ATF_ASSERT_NOW(a_ext_devsel, clk, arst_n, v_s4 && item_s4.ext, item_s4.devsel == DEV_LBA, "48-bit request with nonzero head")

endmodule

// File: rtl/ata_tf_seq.sv
// ----------------------------------------------------------------------------
// ata_tf_seq
// Write sequencer: steps through the task-file writes of one request and
// loads each into the output register.
// ----------------------------------------------------------------------------
`include "ata_taskfile_command_issue_defines.svh"

module ata_tf_seq import ata_tf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        pop,
	input  logic [15:0] command_port_base,
	input  logic [15:0] control_port_base,
	output logic        port_valid,
	input  logic        port_stall,
	output logic [15:0] port_address,
	output logic [7:0]  port_data,
	output logic        last_write
);

	step_t state_q, state_d;
	logic load_out;
	logic sel_ctl;
	logic [2:0] reg_off;
	logic [7:0] data;
	logic last;
	logic out_valid_q;
	logic [15:0] port_address_q;
	logic [7:0] port_data_q;
	logic last_write_q;

	assign load_out = item_valid && (!out_valid_q || !port_stall);
	assign pop = load_out && (state_q == ST_CMD);

	always_comb begin
		state_d = state_q;
		if (load_out) begin
			case (state_q)
				ST_CMD:  state_d = ST_NIEN;
				ST_DEV:  state_d = item.ext ? ST_H_CNT_ON : ST_CNT;
				default: state_d = step_t'(5'(state_q) + 5'd1);
			endcase
		end
	end

	always_comb begin
		sel_ctl = 1'b0;
		reg_off = REG_COMMAND;
		data    = item.cmd;
		last    = 1'b0;
		case (state_q)
			ST_NIEN: begin
				sel_ctl = 1'b1;
				reg_off = REG_DEVCTL;
				data    = CTL_NIEN;
			end
			ST_DEV: begin
				reg_off = REG_DEVSEL;
				data    = item.devsel;
			end
			ST_H_CNT_ON, ST_H_LO_ON, ST_H_MID_ON, ST_H_HI_ON: begin
				sel_ctl = 1'b1;
				reg_off = REG_DEVCTL;
				data    = CTL_HOB_ON;
			end
			ST_H_CNT_OFF, ST_H_LO_OFF, ST_H_MID_OFF, ST_H_HI_OFF: begin
				sel_ctl = 1'b1;
				reg_off = REG_DEVCTL;
				data    = CTL_HOB_OFF;
			end
			ST_H_CNT: begin
				reg_off = REG_SECCNT;
				data    = 8'h00;
			end
			ST_H_LO: begin
				reg_off = REG_LBA_LO;
				data    = item.hob_lba;
			end
			ST_H_MID: begin
				reg_off = REG_LBA_MID;
				data    = 8'h00;
			end
			ST_H_HI: begin
				reg_off = REG_LBA_HI;
				data    = 8'h00;
			end
			ST_CNT: begin
				reg_off = REG_SECCNT;
				data    = item.count;
			end
			ST_HI: begin
				reg_off = REG_LBA_HI;
				data    = item.b2;
			end
			ST_MID: begin
				reg_off = REG_LBA_MID;
				data    = item.b1;
			end
			ST_LO: begin
				reg_off = REG_LBA_LO;
				data    = item.b0;
			end
			ST_CMD: begin
				reg_off = REG_COMMAND;
				data    = item.cmd;
				last    = 1'b1;
			end
			default: begin
				reg_off = REG_COMMAND;
				data    = item.cmd;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_NIEN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!port_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			port_address_q <= (sel_ctl ? control_port_base : command_port_base) + 16'(reg_off);
			port_data_q    <= data;
			last_write_q   <= last;
		end
	end

	assign port_valid   = out_valid_q;
	assign port_address = port_address_q;
	assign port_data    = port_data_q;
	assign last_write   = last_write_q;

	`ATF_ASSERT_NEXT(a_last_on_cmd, clk, arst_n, load_out && (state_q == ST_CMD), last_write_q && out_valid_q, "command write not flagged last")
	`ATF_ASSERT_NOW(a_no_hob_short, clk, arst_n, item_valid && !item.ext, (state_q <= ST_DEV) || (state_q >= ST_CNT), "HOB step on a short sequence")
	`ATF_ASSERT_NEXT(a_restart, clk, arst_n, pop, state_q == ST_NIEN, "sequencer did not restart after command")

endmodule

// File: rtl/ata_taskfile_command_issue.sv
// ----------------------------------------------------------------------------
// ata_taskfile_command_issue
// Turns a disk access request into the ordered ATA task-file port writes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall): read or write, block address and
//   sector count. Port channel (port_valid/port_stall): one register write per
//   transaction, last_write marks the command write that ends a request.
//   Config channel (cfg_valid/cfg_ready, cfg_index/cfg_data) sets the LBA
//   capability and both port bases; cfg_ready is always high.
// Timing:
//   The first write of a request passes the input, product, correction and
//   decode registers and then the output register. A request yields 19 writes
//   in 48-bit mode and 7 otherwise, one per cycle from the output register
//   while port_stall is low, so the sequencer sets the request rate. Requests
//   are taken back to back; up to three more wait in the address pipeline
//   while writes drain. A stalled write holds in the output register and the
//   stall backs up through the pipeline to req_stall.
// Reset:
//   arst_n clears all valid flags and the sequencer; the config registers
//   return to no LBA support, command base 0x1F0 and control base 0x3F6.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issue import ata_tf_pkg::*; #(
	parameter int SECTORS_PER_TRACK = SPT_DEFAULT,
	parameter int HEADS = HEADS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  req_type,
	input  logic [31:0]           block_address,
	input  logic [7:0]            sector_count,
	output logic                  port_valid,
	input  logic                  port_stall,
	output logic [15:0]           port_address,
	output logic [7:0]            port_data,
	output logic                  last_write
);

	logic lba_supported_q;
	logic [15:0] command_port_base_q;
	logic [15:0] control_port_base_q;
	item_t item;
	logic item_valid;
	logic pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lba_supported_q     <= 1'b0;
			command_port_base_q <= COMMAND_BASE_RST;
			control_port_base_q <= CONTROL_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LBA_SUPPORTED: lba_supported_q     <= cfg_data[0];
				CFG_COMMAND_BASE:  command_port_base_q <= cfg_data;
				CFG_CONTROL_BASE:  control_port_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ata_tf_addr #(
		.SECTORS_PER_TRACK(SECTORS_PER_TRACK),
		.HEADS(HEADS)
	) u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.block_address(block_address),
		.sector_count(sector_count),
		.lba_supported(lba_supported_q),
		.item(item),
		.item_valid(item_valid),
		.pop(pop)
	);

	ata_tf_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.pop(pop),
		.command_port_base(command_port_base_q),
		.control_port_base(control_port_base_q),
		.port_valid(port_valid),
		.port_stall(port_stall),
		.port_address(port_address),
		.port_data(port_data),
		.last_write(last_write)
	);

endmodule
